@@ hdl/msd_pkg.sv @@
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types, codes and the code pattern table of the Morse stream decoder.
// ----------------------------------------------------------------------------
package msd_pkg;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int unsigned SYM_W  = 2;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned PAT_W  = 5;
  localparam int unsigned LEN_W  = 3;
  localparam int unsigned RUN_W  = 3;
  localparam int unsigned GAP_W  = 3;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [SYM_W-1:0]  sym_t;
  typedef logic [GAP_W-1:0]  gap_t;

  // input symbol codes
  localparam sym_t SYM_DOT   = 2'd0;
  localparam sym_t SYM_DASH  = 2'd1;
  localparam sym_t SYM_SLASH = 2'd2;
  localparam sym_t SYM_EOM   = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_WORD_GAP = 2'd0;
  localparam cfg_idx_t CFG_SENT_GAP = 2'd1;

  localparam gap_t WORD_GAP_RST = 3'd3;
  localparam gap_t SENT_GAP_RST = 3'd5;

  // pattern length marks
  localparam logic [LEN_W-1:0] PAT_MAX      = 3'd5;
  localparam logic [LEN_W-1:0] PAT_OVERLONG = 3'd6;
  localparam logic [RUN_W-1:0] RUN_MAX      = 3'd7;

  // ascii characters
  localparam char_t CHR_NONE    = 7'h00;
  localparam char_t CHR_SPACE   = 7'h20;
  localparam char_t CHR_PERIOD  = 7'h2e;
  localparam char_t CHR_NEWLINE = 7'h0a;

  // one queued job: up to two characters caused by one symbol
  typedef struct packed {
    logic  c0_vld;
    char_t c0;
    logic  c1_vld;
    char_t c1;
  } job_t;

  // pattern to character, first element in the msb of the used bits, dash = 1
  function automatic char_t morse_lookup(input logic [LEN_W-1:0] len,
                                         input logic [PAT_W-1:0] bits);
    char_t c;
    c = CHR_NONE;
    case (len)
      3'd1: begin
        case (bits)
          5'b00000: c = 7'("E");
          5'b00001: c = 7'("T");
          default:  c = CHR_NONE;
        endcase
      end
      3'd2: begin
        case (bits)
          5'b00000: c = 7'("I");
          5'b00001: c = 7'("A");
          5'b00010: c = 7'("N");
          5'b00011: c = 7'("M");
          default:  c = CHR_NONE;
        endcase
      end
      3'd3: begin
        case (bits)
          5'b00000: c = 7'("S");
          5'b00001: c = 7'("U");
          5'b00010: c = 7'("R");
          5'b00011: c = 7'("W");
          5'b00100: c = 7'("D");
          5'b00101: c = 7'("K");
          5'b00110: c = 7'("G");
          5'b00111: c = 7'("O");
          default:  c = CHR_NONE;
        endcase
      end
      3'd4: begin
        case (bits)
          5'b00000: c = 7'("H");
          5'b00001: c = 7'("V");
          5'b00010: c = 7'("F");
          5'b00100: c = 7'("L");
          5'b00110: c = 7'("P");
          5'b00111: c = 7'("J");
          5'b01000: c = 7'("B");
          5'b01001: c = 7'("X");
          5'b01010: c = 7'("C");
          5'b01011: c = 7'("Y");
          5'b01100: c = 7'("Z");
          5'b01101: c = 7'("Q");
          default:  c = CHR_NONE;
        endcase
      end
      3'd5: begin
        case (bits)
          5'b11111: c = 7'("0");
          5'b01111: c = 7'("1");
          5'b00111: c = 7'("2");
          5'b00011: c = 7'("3");
          5'b00001: c = 7'("4");
          5'b00000: c = 7'("5");
          5'b10000: c = 7'("6");
          5'b11000: c = 7'("7");
          5'b11100: c = 7'("8");
          5'b11110: c = 7'("9");
          default:  c = CHR_NONE;
        endcase
      end
      default: c = CHR_NONE;
    endcase
    return c;
  endfunction

endpackage

@@ hdl/msd_intf.sv @@
// ----------------------------------------------------------------------------
// msd interfaces
// Valid/ready channels for symbols, decoded characters and register writes.
// ----------------------------------------------------------------------------
interface msd_sym_if;
  import msd_pkg::*;
  logic valid;
  logic ready;
  sym_t symbol;
  modport source (output valid, output symbol, input ready);
  modport sink (input valid, input symbol, output ready);
endinterface

interface msd_chr_if;
  import msd_pkg::*;
  logic  valid;
  logic  ready;
  char_t character;
  logic  last;
  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

interface msd_cfg_if;
  import msd_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  gap_t     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/msd_front.sv @@
// ----------------------------------------------------------------------------
// msd_front
// Takes symbols, keeps the pattern and slash run state and the gap registers,
// and turns each symbol into a job of up to two characters for the queue.
// ----------------------------------------------------------------------------
module msd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  msd_sym_if.sink         sym_i,
  msd_cfg_if.sink         cfg_i,
  output logic            push_o,
  output msd_pkg::job_t   job_o,
  input  logic            push_ready_i
);
  import msd_pkg::*;

  logic [PAT_W-1:0] bits_q, bits_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [RUN_W-1:0] run_q, run_d;
  gap_t             word_gap_q, sent_gap_q;
  logic             accept;
  char_t            sep_chr, pat_chr;
  job_t             job;

  // gap registers, always writable
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_gap_q <= WORD_GAP_RST;
      sent_gap_q <= SENT_GAP_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_WORD_GAP) word_gap_q <= cfg_i.data;
      if (cfg_i.index == CFG_SENT_GAP) sent_gap_q <= cfg_i.data;
    end
  end

  // a symbol goes in when the queue has room
  assign sym_i.ready = push_ready_i;
  assign accept      = sym_i.valid && push_ready_i;

  // separator for the open slash run, space wins over period
  always_comb begin
    if (run_q == word_gap_q)      sep_chr = CHR_SPACE;
    else if (run_q == sent_gap_q) sep_chr = CHR_PERIOD;
    else                          sep_chr = CHR_NONE;
  end

  assign pat_chr = morse_lookup(len_q, bits_q);

  // classify the symbol and work out the next state
  always_comb begin
    bits_d = bits_q;
    len_d  = len_q;
    run_d  = run_q;
    job    = '0;
    case (sym_i.symbol)
      SYM_DOT, SYM_DASH: begin
        if (run_q != '0) begin
          job.c0     = sep_chr;
          job.c0_vld = (sep_chr != CHR_NONE);
          run_d      = '0;
        end
        if (len_q < PAT_MAX) begin
          bits_d = {bits_q[PAT_W-2:0], sym_i.symbol[0]};
          len_d  = len_q + 3'd1;
        end else begin
          len_d = PAT_OVERLONG;
        end
      end
      SYM_SLASH: begin
        if (run_q == '0) begin
          job.c0     = pat_chr;
          job.c0_vld = (pat_chr != CHR_NONE);
          bits_d     = '0;
          len_d      = '0;
        end
        if (run_q < RUN_MAX) run_d = run_q + 3'd1;
      end
      default: begin
        job.c0     = (run_q != '0) ? sep_chr : pat_chr;
        job.c0_vld = (job.c0 != CHR_NONE);
        job.c1     = CHR_NEWLINE;
        job.c1_vld = 1'b1;
        bits_d     = '0;
        len_d      = '0;
        run_d      = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
      len_q  <= '0;
      run_q  <= '0;
    end else if (accept) begin
      bits_q <= bits_d;
      len_q  <= len_d;
      run_q  <= run_d;
    end
  end

  // only jobs that carry a character enter the queue
  assign push_o = accept && (job.c0_vld || job.c1_vld);
  assign job_o  = job;

endmodule

@@ hdl/msd_queue.sv @@
// ----------------------------------------------------------------------------
// msd_queue
// Small job queue that lets the front and the back stall on their own.
// ----------------------------------------------------------------------------
module msd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  msd_pkg::job_t   job_i,
  output logic            push_ready_o,
  output logic            head_valid_o,
  output msd_pkg::job_t   head_o,
  input  logic            pop_i
);
  import msd_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count above depth");

  a_no_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q == $past(count_q) + 1'b1)
    else $error("push did not grow the queue");
`endif

endmodule

@@ hdl/msd_back.sv @@
// ----------------------------------------------------------------------------
// msd_back
// Drains jobs from the queue one character at a time into the output register
// and marks the final character of each job as last.
// ----------------------------------------------------------------------------
module msd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  msd_pkg::job_t   head_i,
  output logic            pop_o,
  msd_chr_if.source       chr_o
);
  import msd_pkg::*;

  logic  valid_q;
  char_t char_q, char_d;
  logic  last_q, last_d;
  logic  second_q, second_d;
  logic  load;

  // output register takes a new word when empty or being drained
  assign load = head_valid_i && (!valid_q || chr_o.ready);

  // pick the character of the head job
  always_comb begin
    second_d = second_q;
    pop_o    = 1'b0;
    if (!second_q && head_i.c0_vld) begin
      char_d = head_i.c0;
      last_d = !head_i.c1_vld;
      if (load) begin
        if (head_i.c1_vld) second_d = 1'b1;
        else               pop_o    = load;
      end
    end else begin
      char_d = head_i.c1;
      last_d = 1'b1;
      if (load) begin
        second_d = 1'b0;
        pop_o    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      second_q <= second_d;
      if (load)             valid_q <= 1'b1;
      else if (chr_o.ready) valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_d;
      last_q <= last_d;
    end
  end

  assign chr_o.valid     = valid_q;
  assign chr_o.character = char_q;
  assign chr_o.last      = last_q;

`ifndef SYNTHESIS
  a_second_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> head_valid_i && head_i.c0_vld && head_i.c1_vld)
    else $error("second character pending without a two-character job");

  a_pop_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> valid_q && last_q)
    else $error("job popped before its last character was loaded");

  a_word_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chr_o.valid && !chr_o.ready |=>
      chr_o.valid && $stable(chr_o.character) && $stable(chr_o.last))
    else $error("output word changed while stalled");
`endif

endmodule

@@ hdl/morse_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// morse_stream_decoder
// Decodes a stream of Morse symbols into ASCII letters, digits and separators.
// ----------------------------------------------------------------------------
// One symbol is taken per clock cycle while the queue has room (dot, dash,
// slash, end of message). The front updates the pattern and slash run state
// in the cycle of acceptance and places the characters that symbol causes
// into a four-job queue; the back sends them out from a registered output,
// one word per cycle while the receiver is ready. A symbol causes at most
// two words, and only end of message causes two, so the output port is what
// limits the sustained rate: one word per cycle, end of message needing two
// words. The gap registers (index 0 word gap, index 1 sentence gap) must be
// written by the user only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module morse_stream_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  msd_sym_if.sink   sym_i,
  msd_cfg_if.sink   cfg_i,
  msd_chr_if.source chr_o
);
  import msd_pkg::*;

  logic push, push_ready, head_valid, pop;
  job_t job, head;

  // symbol classification and state
  msd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sym_i        (sym_i),
    .cfg_i        (cfg_i),
    .push_o       (push),
    .job_o        (job),
    .push_ready_i (push_ready)
  );

  // job queue
  msd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_i        (job),
    .push_ready_o (push_ready),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // character output
  msd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .chr_o        (chr_o)
  );

endmodule
